>>> hdl/mrac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_pkg
// Types, widths and the operation table of the adaptive drive block.
// ----------------------------------------------------------------------------
package mrac_pkg;

    localparam int SIG_W      = 32;
    localparam int GAIN_W     = 48;
    localparam int RATE_W     = 48;
    localparam int LIM_W      = 31;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int SUM_W      = 66;
    localparam int ACC_W      = 128;
    localparam int MID_W      = 80;
    localparam int WORD_W     = 32;
    localparam int PP_W       = 64;
    localparam int RES_W      = 64;
    localparam int OP_W       = 4;
    localparam int DRV_FRAC   = 16;

    localparam logic [OP_W-1:0] OP_LAST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_X,
        CFG_RATE_R,
        CFG_RATE_TH,
        CFG_POLE,
        CFG_GSTEP,
        CFG_START_KX,
        CFG_START_KR,
        CFG_LIMIT
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0] rate_x;
        logic [RATE_W-1:0] rate_r;
        logic [RATE_W-1:0] rate_th;
        logic [GAIN_W-1:0] pole;
        logic [GAIN_W-1:0] gstep;
        logic [GAIN_W-1:0] start_kx;
        logic [GAIN_W-1:0] start_kr;
        logic [LIM_W-1:0]  limit;
    } t_cfg;

    typedef enum logic [2:0] {A_X, A_R, A_E, A_MODEL, A_MID} t_asel;

    typedef enum logic [2:0] {
        B_GREF, B_GSTATE, B_E, B_RATE_X, B_RATE_R, B_RATE_TH, B_GSTEP, B_POLE
    } t_bsel;

    typedef enum logic [2:0] {RND_RAW, RND_16, RND_32, RND_48, RND_64} t_rnd;

    typedef enum logic [2:0] {
        DST_SUM, DST_MID, DST_GX, DST_GR, DST_TH, DST_TM, DST_MODEL
    } t_dst;

    typedef struct packed {
        t_asel      a_sel;
        t_bsel      b_sel;
        logic [1:0] a_last;
        t_rnd       rnd;
        t_dst       dst;
    } t_op;

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_MUL, S_DRAIN, S_WB, S_FIN} t_state;

    typedef struct packed {
        logic       load_in;
        logic       setup;
        logic       acc_init;
        logic       mul_en;
        logic       acc_add;
        logic       wb;
        logic       out_load;
        t_op        op;
        logic [1:0] a_idx;
        logic       b_idx;
    } t_cmd;

    typedef struct packed {
        logic action;
    } t_status;

    function automatic t_op op_def(input logic [OP_W-1:0] idx);
        t_op op;
        case (idx)
            4'd0:    op = '{a_sel: A_R,     b_sel: B_GREF,    a_last: 2'd0,
                            rnd: RND_16,  dst: DST_SUM};
            4'd1:    op = '{a_sel: A_X,     b_sel: B_GSTATE,  a_last: 2'd0,
                            rnd: RND_16,  dst: DST_SUM};
            4'd2:    op = '{a_sel: A_X,     b_sel: B_E,       a_last: 2'd0,
                            rnd: RND_RAW, dst: DST_MID};
            4'd3:    op = '{a_sel: A_MID,   b_sel: B_RATE_X,  a_last: 2'd2,
                            rnd: RND_64,  dst: DST_GX};
            4'd4:    op = '{a_sel: A_R,     b_sel: B_E,       a_last: 2'd0,
                            rnd: RND_RAW, dst: DST_MID};
            4'd5:    op = '{a_sel: A_MID,   b_sel: B_RATE_R,  a_last: 2'd2,
                            rnd: RND_64,  dst: DST_GR};
            4'd6:    op = '{a_sel: A_E,     b_sel: B_RATE_TH, a_last: 2'd1,
                            rnd: RND_48,  dst: DST_TH};
            4'd7:    op = '{a_sel: A_R,     b_sel: B_GSTEP,   a_last: 2'd0,
                            rnd: RND_16,  dst: DST_TM};
            default: op = '{a_sel: A_MODEL, b_sel: B_POLE,    a_last: 2'd1,
                            rnd: RND_32,  dst: DST_MODEL};
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

>>> hdl/mrac_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_ifs
// Valid/ready channels: input words, result words and register writes.
// ----------------------------------------------------------------------------
interface mrac_in_if import mrac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [SIG_W-1:0]  measured;
    logic [SIG_W-1:0]  reference;

    modport source (output valid, output action, output measured, output reference,
                    input ready);
    modport sink   (input valid, input action, input measured, input reference,
                    output ready);
endinterface

interface mrac_out_if import mrac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIG_W-1:0]  drive;
    logic              clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface mrac_cfg_if import mrac_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/mrac_first_order_adaptive_drive.sv
`default_nettype none
// Control step: an input word is taken only while the sequencer is idle, so a
// new word waits until the result of the last one is loaded for output. The
// shared 32x32 multiply-accumulate unit walks the nine table operations, each
// as word products, drain and write-back; a restart word skips all of them.
// Synchronous active-low reset loads the register defaults and zeroes gains,
// offset and model state; no clearing pass.
// ----------------------------------------------------------------------------
// mrac_first_order_adaptive_drive
// First-order MRAC drive with MIT-rule adaptation in fixed point.
// ----------------------------------------------------------------------------
module mrac_first_order_adaptive_drive import mrac_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrac_in_if.sink     i_in,
    mrac_out_if.source  o_out,
    mrac_cfg_if.sink    i_cfg
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    mrac_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    mrac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_action    (i_in.action),
        .i_measured  (i_in.measured),
        .i_reference (i_in.reference),
        .o_status    (status),
        .o_drive     (o_out.drive),
        .o_clamped   (o_out.clamped)
    );

    mrac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

endmodule
`default_nettype wire

>>> hdl/mrac_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_cfg_regs
// Configuration register file: rates, model steps, start gains, drive limit.
// ----------------------------------------------------------------------------
module mrac_cfg_regs import mrac_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_x   <= 48'd28147498;
            r_cfg.rate_r   <= 48'd14073749;
            r_cfg.rate_th  <= 48'd140737488355;
            r_cfg.pole     <= '0;
            r_cfg.gstep    <= '0;
            r_cfg.start_kx <= '0;
            r_cfg.start_kr <= '0;
            r_cfg.limit    <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_RATE_X:   r_cfg.rate_x   <= i_wr_data;
                CFG_RATE_R:   r_cfg.rate_r   <= i_wr_data;
                CFG_RATE_TH:  r_cfg.rate_th  <= i_wr_data;
                CFG_POLE:     r_cfg.pole     <= i_wr_data;
                CFG_GSTEP:    r_cfg.gstep    <= i_wr_data;
                CFG_START_KX: r_cfg.start_kx <= i_wr_data;
                CFG_START_KR: r_cfg.start_kr <= i_wr_data;
                CFG_LIMIT:    r_cfg.limit    <= i_wr_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hdl/mrac_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_ctrl
// Sequencer: walks the operation table over the shared multiplier.
// ----------------------------------------------------------------------------
module mrac_ctrl import mrac_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  t_status   i_status,
    output t_cmd      o_cmd
);

    t_state          r_state, n_state;
    logic [OP_W-1:0] r_op, n_op;
    logic [1:0]      r_a_idx, n_a_idx;
    logic            r_b_idx, n_b_idx;
    logic            r_out_valid, n_out_valid;
    t_op             op;

    assign op = op_def(r_op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= '0;
            r_a_idx     <= '0;
            r_b_idx     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_a_idx     <= n_a_idx;
            r_b_idx     <= n_b_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a_idx     = r_a_idx;
        n_b_idx     = r_b_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = op;
        o_cmd.a_idx = r_a_idx;
        o_cmd.b_idx = r_b_idx;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_op        = '0;
                n_a_idx     = '0;
                n_b_idx     = 1'b0;
                n_state     = i_status.action ? S_FIN : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_a_idx == '0 && !r_b_idx) begin
                    o_cmd.acc_init = 1'b1;
                end else begin
                    o_cmd.acc_add = 1'b1;
                end
                if (r_b_idx) begin
                    n_b_idx = 1'b0;
                    if (r_a_idx == op.a_last) begin
                        n_a_idx = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_a_idx = r_a_idx + 2'd1;
                    end
                end else begin
                    n_b_idx = 1'b1;
                end
            end
            S_DRAIN: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_op == OP_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_op    = r_op + 4'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> hdl/mrac_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_dp
// Datapath: adaptive state, shared 32x32 multiply-accumulate, drive clamp.
// ----------------------------------------------------------------------------
module mrac_dp import mrac_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_cfg                  i_cfg,
    input  wire logic             i_action,
    input  wire logic [SIG_W-1:0] i_measured,
    input  wire logic [SIG_W-1:0] i_reference,
    output t_status               o_status,
    output logic [SIG_W-1:0]      o_drive,
    output logic                  o_clamped
);

    localparam int A_W = 4 * WORD_W;
    localparam int B_W = 2 * WORD_W;

    function automatic logic [SIG_W-1:0] mag32(input logic [SIG_W-1:0] v);
        return v[SIG_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [GAIN_W-1:0] mag48(input logic [GAIN_W-1:0] v);
        return v[GAIN_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [GAIN_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [GAIN_W-1:0] s;
        if (&v[SUM_W-1:GAIN_W-1] || ~|v[SUM_W-1:GAIN_W-1]) begin
            s = v[GAIN_W-1:0];
        end else if (v[SUM_W-1]) begin
            s = {1'b1, {(GAIN_W-1){1'b0}}};
        end else begin
            s = {1'b0, {(GAIN_W-1){1'b1}}};
        end
        return s;
    endfunction

    logic signed [SIG_W-1:0]  r_x, r_r;
    logic                     r_action;
    logic signed [GAIN_W-1:0] r_e, r_gain_state, r_gain_ref, r_offset, r_model;
    logic signed [SUM_W-1:0]  r_sum, r_tm;
    logic [MID_W-1:0]         r_mid;
    logic                     r_mid_neg;
    logic [PP_W-1:0]          r_pp;
    logic [1:0]               r_pp_pos;
    logic [ACC_W-1:0]         r_acc;
    logic [SIG_W-1:0]         r_drive;
    logic                     r_clamped;

    logic [A_W-1:0]           a_full;
    logic                     a_neg;
    logic [B_W-1:0]           b_full;
    logic                     b_neg;
    logic [WORD_W-1:0]        a_word, b_word;
    logic [ACC_W-1:0]         acc_seed;
    logic [RES_W-1:0]         res_mag;
    logic                     res_neg;
    logic signed [RES_W-1:0]  res;
    logic signed [SUM_W-1:0]  lim;
    logic [SUM_W-1:0]         sum_abs;
    logic [SUM_W-1:0]         sum_rnd;
    logic [SIG_W-1:0]         drv_mag;
    logic [SIG_W-1:0]         lim_word;
    logic [SIG_W-1:0]         n_drive;
    logic                     n_clamped;

    always_comb begin
        case (i_cmd.op.a_sel)
            A_X:     begin a_full = A_W'(mag32(r_x));     a_neg = r_x[SIG_W-1];     end
            A_R:     begin a_full = A_W'(mag32(r_r));     a_neg = r_r[SIG_W-1];     end
            A_E:     begin a_full = A_W'(mag48(r_e));     a_neg = r_e[GAIN_W-1];    end
            A_MODEL: begin a_full = A_W'(mag48(r_model)); a_neg = r_model[GAIN_W-1]; end
            A_MID:   begin a_full = A_W'(r_mid);          a_neg = r_mid_neg;        end
            default: begin a_full = '0;                   a_neg = 1'b0;             end
        endcase
    end

    always_comb begin
        unique case (i_cmd.op.b_sel)
            B_GREF:    begin b_full = B_W'(mag48(r_gain_ref));   b_neg = r_gain_ref[GAIN_W-1];
            end
            B_GSTATE:  begin b_full = B_W'(mag48(r_gain_state)); b_neg = r_gain_state[GAIN_W-1];
            end
            B_E:       begin b_full = B_W'(mag48(r_e));          b_neg = r_e[GAIN_W-1];   end
            B_RATE_X:  begin b_full = B_W'(i_cfg.rate_x);        b_neg = 1'b0;            end
            B_RATE_R:  begin b_full = B_W'(i_cfg.rate_r);        b_neg = 1'b0;            end
            B_RATE_TH: begin b_full = B_W'(i_cfg.rate_th);       b_neg = 1'b0;            end
            B_GSTEP:   begin b_full = B_W'(mag48(i_cfg.gstep));  b_neg = i_cfg.gstep[GAIN_W-1];
            end
            B_POLE:    begin b_full = B_W'(mag48(i_cfg.pole));   b_neg = i_cfg.pole[GAIN_W-1];
            end
        endcase
    end

    assign a_word = a_full[WORD_W*i_cmd.a_idx +: WORD_W];
    assign b_word = b_full[WORD_W*i_cmd.b_idx +: WORD_W];

    always_comb begin
        case (i_cmd.op.rnd)
            RND_16:  begin acc_seed = ACC_W'(1) << 15; res_mag = r_acc[16 +: RES_W]; end
            RND_32:  begin acc_seed = ACC_W'(1) << 31; res_mag = r_acc[32 +: RES_W]; end
            RND_48:  begin acc_seed = ACC_W'(1) << 47; res_mag = r_acc[48 +: RES_W]; end
            RND_64:  begin acc_seed = ACC_W'(1) << 63; res_mag = r_acc[64 +: RES_W]; end
            default: begin acc_seed = '0;              res_mag = r_acc[RES_W-1:0];  end
        endcase
    end

    assign res_neg = a_neg ^ b_neg;
    assign res     = res_neg ? -$signed(res_mag) : $signed(res_mag);

    always_comb begin
        lim      = $signed(SUM_W'({i_cfg.limit, {DRV_FRAC{1'b0}}}));
        sum_abs  = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
        sum_rnd  = sum_abs + (SUM_W'(1) << (DRV_FRAC - 1));
        drv_mag  = sum_rnd[DRV_FRAC +: SIG_W];
        lim_word = SIG_W'(i_cfg.limit);
        priority if (r_action) begin
            n_drive   = '0;
            n_clamped = 1'b0;
        end else if (r_sum > lim) begin
            n_drive   = lim_word;
            n_clamped = 1'b1;
        end else if (r_sum < -lim) begin
            n_drive   = ~lim_word + 1'b1;
            n_clamped = 1'b1;
        end else begin
            n_drive   = r_sum[SUM_W-1] ? (~drv_mag + 1'b1) : drv_mag;
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_state <= '0;
            r_gain_ref   <= '0;
            r_offset     <= '0;
            r_model      <= '0;
        end else if (i_cmd.setup && r_action) begin
            r_gain_state <= $signed(i_cfg.start_kx);
            r_gain_ref   <= $signed(i_cfg.start_kr);
            r_offset     <= '0;
            r_model      <= '0;
        end else if (i_cmd.wb) begin
            case (i_cmd.op.dst)
                DST_GX:    r_gain_state <= sat48(SUM_W'(r_gain_state) - SUM_W'(res));
                DST_GR:    r_gain_ref   <= sat48(SUM_W'(r_gain_ref) - SUM_W'(res));
                DST_TH:    r_offset     <= sat48(SUM_W'(r_offset) - SUM_W'(res));
                DST_MODEL: r_model      <= sat48(r_tm + SUM_W'(res));
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x      <= $signed(i_measured);
            r_r      <= $signed(i_reference);
            r_action <= i_action;
        end
        if (i_cmd.setup) begin
            r_e   <= sat48((SUM_W'(r_x) <<< DRV_FRAC) - SUM_W'(r_model));
            r_sum <= SUM_W'(r_offset);
            r_tm  <= SUM_W'(r_model);
        end
        if (i_cmd.mul_en) begin
            r_pp     <= PP_W'(a_word) * PP_W'(b_word);
            r_pp_pos <= i_cmd.a_idx + 2'(i_cmd.b_idx);
        end
        if (i_cmd.acc_init) begin
            r_acc <= acc_seed;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + (ACC_W'(r_pp) << {r_pp_pos, 5'b0});
        end
        if (i_cmd.wb) begin
            case (i_cmd.op.dst)
                DST_SUM: r_sum <= r_sum + SUM_W'(res);
                DST_TM:  r_tm  <= r_tm + SUM_W'(res);
                DST_MID: begin
                    r_mid     <= r_acc[MID_W-1:0];
                    r_mid_neg <= res_neg;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_status.action = r_action;
    assign o_drive         = r_drive;
    assign o_clamped       = r_clamped;

endmodule
`default_nettype wire

>>> hdl/mrac_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrac_checker
// Port-level checks of the adaptive drive block, bound to the top level.
// ----------------------------------------------------------------------------
module mrac_checker import mrac_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [SIG_W-1:0]      i_drive,
    input wire logic                  i_clamped,
    input wire logic                  i_cfg_valid,
    input wire logic                  i_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]              r_pend;
    logic [LIM_W-1:0]        r_lim;
    logic                    in_acc, out_acc;
    logic signed [SIG_W-1:0] lim_pos, lim_neg, drv;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;
    assign lim_pos = $signed({1'b0, r_lim});
    assign lim_neg = -lim_pos;
    assign drv     = $signed(i_drive);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_lim  <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
            if (i_cfg_valid && i_cfg_ready && i_cfg_index == CFG_LIMIT) begin
                r_lim <= i_cfg_data[LIM_W-1:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive) && $stable(i_clamped))
        else $error("result word changed while stalled");

    a_out_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result word without an accepted input word");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken again right after acceptance");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clamped |-> drv == lim_pos || drv == lim_neg)
        else $error("clamped drive not at the limit");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_clamped |-> drv <= lim_pos && drv >= lim_neg)
        else $error("unclamped drive beyond the limit");

endmodule

bind mrac_first_order_adaptive_drive mrac_checker u_mrac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive     (o_out.drive),
    .i_clamped   (o_out.clamped),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data)
);
`default_nettype wire

>>> tb/sv/mrac_first_order_adaptive_drive_tb.sv
// ----------------------------------------------------------------------------
// mrac_first_order_adaptive_drive_tb
// Self-checking bench for the adaptive drive: a bit-exact predictor tracks the
// gains, offset and model state and every result word is compared in order.
// Directed tests cover reset defaults, clamping, restart, error saturation and
// ignored register indexes. Randomized phases then run with random gaps and
// stalls on both channels.
// ----------------------------------------------------------------------------
module mrac_first_order_adaptive_drive_tb;
    import mrac_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [SIG_W-1:0] drive;
        logic             clamped;
    } drive_word_t;

    typedef enum int {MIX_TYPICAL, MIX_WILD, MIX_TOP, MIX_BOTTOM} cfg_mix_t;

    localparam logic ACT_STEP    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam logic [SIG_W-1:0]  SIG_MAX     = 32'h7FFF_FFFF;
    localparam logic [SIG_W-1:0]  SIG_MIN     = 32'h8000_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [GAIN_W-1:0] GAIN_MIN    = 48'h8000_0000_0000;
    localparam logic [RATE_W-1:0] RATE_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [LIM_W-1:0]  LIMIT_MAX   = 31'h7FFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_X_RST  = 48'd28147498;
    localparam logic [RATE_W-1:0] RATE_R_RST  = 48'd14073749;
    localparam logic [RATE_W-1:0] RATE_TH_RST = 48'd140737488355;

    localparam wide_t GAIN_HI = (wide_t'(1) <<< 47) - 1;
    localparam wide_t GAIN_LO = -(wide_t'(1) <<< 47);

    localparam int IDLE_MAX      = 11;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_BOUND   = 5000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam int RESTART_ODDS  = 20;
    localparam int RUN_LIMIT     = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mrac_in_if  in_if  ();
    mrac_out_if out_if ();
    mrac_cfg_if cfg_if ();

    mrac_first_order_adaptive_drive DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_cfg                     cfg_sh;
    logic signed [GAIN_W-1:0] kx_est, kr_est, theta_est, ym_est;
    drive_word_t              drive_expect_q [$];
    int                       fail_count = 0;
    bit                       no_idle = 1'b0;

    function automatic logic signed [GAIN_W-1:0] clip48(input wide_t v);
        if (v > GAIN_HI) return GAIN_HI[GAIN_W-1:0];
        if (v < GAIN_LO) return GAIN_LO[GAIN_W-1:0];
        return v[GAIN_W-1:0];
    endfunction

    // round to nearest, ties away from zero
    function automatic wide_t round_shift(input wide_t p, input int sh);
        wide_t m, q;
        m = (p < 0) ? -p : p;
        q = (m + (wide_t'(1) <<< (sh - 1))) >>> sh;
        return (p < 0) ? -q : q;
    endfunction

    function automatic drive_word_t predict_drive(input logic act,
                                                  input logic [SIG_W-1:0] xm,
                                                  input logic [SIG_W-1:0] rf);
        wide_t x, r, e, sum, lim, d, kx, kr, th, ym;
        wide_t rx, rr, rth, pole, gstep, dx, dr, dth, tm;
        drive_word_t w;
        w = '0;
        if (act == ACT_RESTART) begin
            kx_est    = cfg_sh.start_kx;
            kr_est    = cfg_sh.start_kr;
            theta_est = '0;
            ym_est    = '0;
            return w;
        end
        x     = signed'(xm);
        r     = signed'(rf);
        kx    = kx_est;
        kr    = kr_est;
        th    = theta_est;
        ym    = ym_est;
        rx    = cfg_sh.rate_x;
        rr    = cfg_sh.rate_r;
        rth   = cfg_sh.rate_th;
        pole  = signed'(cfg_sh.pole);
        gstep = signed'(cfg_sh.gstep);
        lim   = cfg_sh.limit;
        lim   = lim <<< DRV_FRAC;

        sum = round_shift(kr * r, 16) + round_shift(kx * x, 16) + th;
        if (sum > lim) begin
            d = cfg_sh.limit;
            w.clamped = 1'b1;
        end else if (sum < -lim) begin
            d = cfg_sh.limit;
            d = -d;
            w.clamped = 1'b1;
        end else begin
            d = round_shift(sum, DRV_FRAC);
        end
        w.drive = d[SIG_W-1:0];

        e   = clip48((x <<< 16) - ym);
        dx  = round_shift(x * e * rx, 64);
        dr  = round_shift(r * e * rr, 64);
        dth = round_shift(rth * e, 48);
        tm  = ym + round_shift(r * gstep, 16) + round_shift(ym * pole, 32);

        kx_est    = clip48(kx - dx);
        kr_est    = clip48(kr - dr);
        theta_est = clip48(th - dth);
        ym_est    = clip48(tm);
        return w;
    endfunction

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_bits(input int bits);
        logic [63:0] t;
        t = {$urandom, $urandom};
        return CFG_DATA_W'(t >> (64 - bits));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_span(input int bits);
        wide_t t;
        t = {$urandom, $urandom};
        t = (t <<< (128 - bits)) >>> (128 - bits);
        return t[CFG_DATA_W-1:0];
    endfunction

    function automatic logic [SIG_W-1:0] pick_signal();
        case ($urandom_range(0, 8))
            0:       return SIG_MAX;
            1:       return SIG_MIN;
            2:       return '0;
            3, 4, 5: return $urandom;
            default: return SIG_W'($urandom_range(0, 1 << 21)) - SIG_W'(1 << 20);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_RATE_X:   cfg_sh.rate_x   = val;
            CFG_RATE_R:   cfg_sh.rate_r   = val;
            CFG_RATE_TH:  cfg_sh.rate_th  = val;
            CFG_POLE:     cfg_sh.pole     = val;
            CFG_GSTEP:    cfg_sh.gstep    = val;
            CFG_START_KX: cfg_sh.start_kx = val;
            CFG_START_KR: cfg_sh.start_kr = val;
            CFG_LIMIT:    cfg_sh.limit    = val[LIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_config(input cfg_mix_t mix);
        logic [CFG_DATA_W-1:0] val [CFG_LIMIT+1];
        case (mix)
            MIX_TYPICAL: begin
                val[CFG_RATE_X]   = rand_bits(28);
                val[CFG_RATE_R]   = rand_bits(28);
                val[CFG_RATE_TH]  = rand_bits(40);
                val[CFG_POLE]     = CFG_DATA_W'(0) - rand_bits(26);
                val[CFG_GSTEP]    = rand_bits(26);
                val[CFG_START_KX] = rand_span(34);
                val[CFG_START_KR] = rand_span(34);
                val[CFG_LIMIT]    = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'(LIMIT_MAX)
                                  : CFG_DATA_W'($urandom_range(1 << 16, 1 << 26));
            end
            MIX_WILD: begin
                val[CFG_RATE_X]   = rand_bits(48);
                val[CFG_RATE_R]   = rand_bits(48);
                val[CFG_RATE_TH]  = rand_bits(48);
                val[CFG_POLE]     = rand_span(48);
                val[CFG_GSTEP]    = rand_span(48);
                val[CFG_START_KX] = rand_span(48);
                val[CFG_START_KR] = rand_span(48);
                val[CFG_LIMIT]    = rand_bits(LIM_W);
            end
            MIX_TOP: begin
                val[CFG_RATE_X]   = RATE_MAX;
                val[CFG_RATE_R]   = RATE_MAX;
                val[CFG_RATE_TH]  = RATE_MAX;
                val[CFG_POLE]     = GAIN_MAX;
                val[CFG_GSTEP]    = GAIN_MAX;
                val[CFG_START_KX] = GAIN_MAX;
                val[CFG_START_KR] = GAIN_MAX;
                val[CFG_LIMIT]    = CFG_DATA_W'(LIMIT_MAX);
            end
            default: begin
                val[CFG_RATE_X]   = '0;
                val[CFG_RATE_R]   = '0;
                val[CFG_RATE_TH]  = '0;
                val[CFG_POLE]     = GAIN_MIN;
                val[CFG_GSTEP]    = GAIN_MIN;
                val[CFG_START_KX] = GAIN_MIN;
                val[CFG_START_KR] = GAIN_MIN;
                val[CFG_LIMIT]    = '0;
            end
        endcase
        for (int i = CFG_RATE_X; i <= CFG_LIMIT; i++) write_reg(CFG_IDX_W'(i), val[i]);
    endtask

    task automatic send_word(input logic act, input logic [SIG_W-1:0] xm,
                             input logic [SIG_W-1:0] rf);
        int gap;
        gap = idle_draw();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.measured  <= xm;
        in_if.reference <= rf;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        drive_expect_q.push_back(predict_drive(act, xm, rf));
    endtask

    // hold input until every result word is back, then let the block settle
    task automatic wait_idle();
        int n;
        in_if.valid <= 1'b0;
        n = 0;
        while (drive_expect_q.size() != 0 && n < DRAIN_BOUND) begin
            @(posedge i_clk);
            n++;
        end
        if (drive_expect_q.size() != 0) begin
            $error("%0d result words never arrived", drive_expect_q.size());
            fail_count++;
            drive_expect_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_word(ACT_STEP, '0, '0);
        send_word(ACT_STEP, SIG_MAX, SIG_MAX);
        send_word(ACT_STEP, SIG_MIN, SIG_MIN);
        send_word(ACT_STEP, SIG_MAX, SIG_MIN);
        wait_idle();
    endtask

    task automatic test_register_sweep();
        program_config(MIX_TYPICAL);
        send_word(ACT_RESTART, $urandom, $urandom);
        send_word(ACT_STEP, 32'h0001_0000, 32'h0002_0000);
        send_word(ACT_STEP, 32'hFFFF_0000, 32'h0000_8000);
        send_word(ACT_STEP, 32'h0000_0001, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_drive_clamp();
        program_config(MIX_TOP);
        send_word(ACT_RESTART, SIG_MAX, SIG_MIN);
        send_word(ACT_STEP, SIG_MAX, SIG_MAX);
        send_word(ACT_STEP, SIG_MIN, SIG_MIN);
        wait_idle();
        program_config(MIX_BOTTOM);
        send_word(ACT_RESTART, '0, '0);
        send_word(ACT_STEP, SIG_MAX, SIG_MAX);
        wait_idle();
        write_reg(CFG_LIMIT, CFG_DATA_W'(LIMIT_MAX));
        send_word(ACT_STEP, SIG_MAX, SIG_MAX);
        send_word(ACT_STEP, '0, '0);
        wait_idle();
    endtask

    task automatic test_large_error();
        program_config(MIX_TOP);
        send_word(ACT_RESTART, '0, '0);
        send_word(ACT_STEP, '0, SIG_MIN);
        send_word(ACT_STEP, SIG_MAX, '0);
        send_word(ACT_STEP, SIG_MIN, SIG_MAX);
        wait_idle();
    endtask

    task automatic test_unused_index();
        program_config(MIX_TYPICAL);
        for (int k = 0; k < 3; k++)
            write_reg(CFG_IDX_W'($urandom_range(CFG_LIMIT + 1, (1 << CFG_IDX_W) - 1)),
                      rand_bits(48));
        send_word(ACT_RESTART, '0, '0);
        send_word(ACT_STEP, 32'h0003_0000, 32'h0001_0000);
        send_word(ACT_STEP, 32'hFFFE_0000, 32'hFFFF_0000);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic act;
        for (int phase = 0; phase < PHASES; phase++) begin
            program_config(cfg_mix_t'(phase % 4));
            send_word(ACT_RESTART, pick_signal(), pick_signal());
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                no_idle = (i >= 20 && i < 35);
                if (phase == 0 && i == 40) wait_idle();
                act = ($urandom_range(1, RESTART_ODDS) == 1) ? ACT_RESTART : ACT_STEP;
                send_word(act, pick_signal(), pick_signal());
            end
            no_idle = 1'b0;
            wait_idle();
        end
    endtask

    initial begin
        int stall;
        drive_word_t want;
        out_if.ready <= 1'b0;
        stall = idle_draw();
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (drive_expect_q.size() == 0) begin
                    $error("unexpected result word: drive %0d clamped %0b",
                           $signed(out_if.drive), out_if.clamped);
                    fail_count++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (out_if.drive !== want.drive) begin
                        $error("drive: expected %0d, actual %0d",
                               $signed(want.drive), $signed(out_if.drive));
                        fail_count++;
                    end
                    if (out_if.clamped !== want.clamped) begin
                        $error("clamped: expected %0b, actual %0b",
                               want.clamped, out_if.clamped);
                        fail_count++;
                    end
                end
                stall = idle_draw();
                if (stall != 0) out_if.ready <= 1'b0;
            end else if (out_if.ready !== 1'b1) begin
                if (stall == 0) out_if.ready <= 1'b1;
                else stall--;
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.action    <= ACT_STEP;
        in_if.measured  <= '0;
        in_if.reference <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        cfg_sh = '{rate_x: RATE_X_RST, rate_r: RATE_R_RST, rate_th: RATE_TH_RST,
                   pole: '0, gstep: '0, start_kx: '0, start_kr: '0, limit: '0};
        kx_est    = '0;
        kr_est    = '0;
        theta_est = '0;
        ym_est    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_sweep();
        test_drive_clamp();
        test_large_error();
        test_unused_index();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
